// ===== hdl/tws_pkg.sv =====
// Shared types and constants for the three-wire serial register master.
// No dependencies; every other file imports this package.
`default_nettype none

package tws_pkg;

    localparam int unsigned BITS_PER_BYTE = 8;
    localparam logic [15:0] HALF_PERIOD_RESET = 16'd200;
    localparam logic [7:0]  READ_CMD_MASK = 8'h01;

    localparam logic OP_READ  = 1'b0;
    localparam logic OP_WRITE = 1'b1;

    typedef enum logic [3:0] {
        PH_IDLE    = 4'd0,
        PH_CE_LOW  = 4'd1,
        PH_CLK_LOW = 4'd2,
        PH_CE_HIGH = 4'd3,
        PH_SET     = 4'd4,
        PH_RISE    = 4'd5,
        PH_FALL    = 4'd6,
        PH_STOP    = 4'd7
    } t_phase;

    typedef struct packed {
        logic       start_req;
        logic       opcode;
        logic [7:0] reg_address;
        logic [7:0] write_data;
        logic       data_in;
    } t_in_item;

    typedef struct packed {
        logic       chip_enable;
        logic       serial_clock;
        logic       data_out;
        logic       data_drive;
        logic       busy_res;
        logic       done_res;
        logic [7:0] read_data;
    } t_out_item;

endpackage

`default_nettype wire

// ===== hdl/tws_channels.sv =====
// Valid/ready channel interfaces for tick items, result items and the
// configuration write. Depends on tws_pkg.
`default_nettype none

interface tws_in_if
    import tws_pkg::*;
    ();
    logic     valid;
    logic     ready;
    t_in_item item;

    modport source (output valid, output item, input ready);
    modport sink   (input valid, input item, output ready);
endinterface

interface tws_out_if
    import tws_pkg::*;
    ();
    logic      valid;
    logic      ready;
    t_out_item item;

    modport source (output valid, output item, input ready);
    modport sink   (input valid, input item, output ready);
endinterface

interface tws_cfg_if;
    logic        valid;
    logic        ready;
    logic [15:0] wdata;

    modport source (output valid, output wdata, input ready);
    modport sink   (input valid, input wdata, output ready);
endinterface

`default_nettype wire

// ===== hdl/tws_seq.sv =====
// Phase sequencer: pin phases, bit counter, shift registers and hold timer.
// Advances one tick per accepted item. Depends on tws_pkg.
`default_nettype none

module tws_seq
    import tws_pkg::*;
#(
    parameter int unsigned DELAY_WIDTH = 16
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_step,
    input  wire t_in_item    i_item,
    input  wire logic [15:0] i_half_period,
    output t_out_item        o_result
);

    localparam int unsigned CW = DELAY_WIDTH + 16;

    t_phase                 r_phase, n_phase;
    logic [2:0]             r_bit, n_bit;
    logic [DELAY_WIDTH-1:0] r_wait, n_wait;
    logic [7:0]             r_out_shift, n_out_shift;
    logic [7:0]             r_in_shift, n_in_shift;
    logic [7:0]             r_data_hold, n_data_hold;
    logic                   r_is_read, n_is_read;
    logic                   r_byte_stage, n_byte_stage;
    logic                   n_done;

    logic [CW-1:0] cfg_ext;
    logic [CW-1:0] limit_ext;
    logic [CW-1:0] hold_ext;
    logic [CW-1:0] wait_inc;

    // Zero counts as one tick; clip to what the counter can hold.
    always_comb begin
        cfg_ext   = CW'(i_half_period);
        limit_ext = CW'({DELAY_WIDTH{1'b1}});
        if (i_half_period == 16'd0) begin
            hold_ext = CW'(1);
        end else if (cfg_ext > limit_ext) begin
            hold_ext = limit_ext;
        end else begin
            hold_ext = cfg_ext;
        end
        wait_inc = CW'(r_wait) + CW'(1);
    end

    // Next state
    always_comb begin
        n_phase      = r_phase;
        n_bit        = r_bit;
        n_wait       = r_wait;
        n_out_shift  = r_out_shift;
        n_in_shift   = r_in_shift;
        n_data_hold  = r_data_hold;
        n_is_read    = r_is_read;
        n_byte_stage = r_byte_stage;
        n_done       = 1'b0;
        if (r_phase == PH_IDLE) begin
            if (i_item.start_req) begin
                n_is_read    = (i_item.opcode == OP_READ);
                n_out_shift  = (i_item.opcode == OP_READ) ?
                               (i_item.reg_address | READ_CMD_MASK) : i_item.reg_address;
                n_data_hold  = i_item.write_data;
                if (i_item.opcode == OP_READ) begin
                    n_in_shift = 8'd0;
                end
                n_byte_stage = 1'b0;
                n_bit        = 3'd0;
                n_wait       = '0;
                n_phase      = PH_CE_LOW;
            end
        end else if (wait_inc < hold_ext) begin
            n_wait = wait_inc[DELAY_WIDTH-1:0];
        end else begin
            n_wait = '0;
            case (r_phase)
                PH_CE_LOW:  n_phase = PH_CLK_LOW;
                PH_CLK_LOW: n_phase = PH_CE_HIGH;
                PH_CE_HIGH: begin
                    n_phase      = PH_SET;
                    n_bit        = 3'd0;
                    n_byte_stage = 1'b0;
                end
                PH_SET: begin
                    // sample the released data line just before the rising edge
                    if (r_byte_stage && r_is_read && i_item.data_in) begin
                        n_in_shift[r_bit] = 1'b1;
                    end
                    n_phase = PH_RISE;
                end
                PH_RISE: n_phase = PH_FALL;
                PH_FALL: begin
                    if (r_bit == 3'(BITS_PER_BYTE - 1)) begin
                        if (!r_byte_stage) begin
                            n_byte_stage = 1'b1;
                            n_bit        = 3'd0;
                            n_out_shift  = r_is_read ? 8'd0 : r_data_hold;
                            n_phase      = PH_SET;
                        end else begin
                            n_phase = PH_STOP;
                        end
                    end else begin
                        n_bit   = r_bit + 3'd1;
                        n_phase = PH_SET;
                    end
                end
                PH_STOP: begin
                    n_phase = PH_IDLE;
                    n_done  = 1'b1;
                end
                default: n_phase = PH_IDLE;
            endcase
        end
    end

    // Pin levels after this tick
    always_comb begin
        o_result.chip_enable  = (n_phase inside {PH_CE_HIGH, PH_SET, PH_RISE, PH_FALL});
        o_result.serial_clock = (n_phase == PH_RISE);
        o_result.data_drive   = (n_phase inside {PH_SET, PH_RISE, PH_FALL}) &&
                                !(n_byte_stage && n_is_read);
        o_result.data_out     = o_result.data_drive && n_out_shift[n_bit];
        o_result.busy_res     = (n_phase != PH_IDLE);
        o_result.done_res     = n_done;
        o_result.read_data    = n_in_shift;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_IDLE;
            r_bit        <= 3'd0;
            r_wait       <= '0;
            r_out_shift  <= 8'd0;
            r_in_shift   <= 8'd0;
            r_data_hold  <= 8'd0;
            r_is_read    <= 1'b0;
            r_byte_stage <= 1'b0;
        end else if (i_step) begin
            r_phase      <= n_phase;
            r_bit        <= n_bit;
            r_wait       <= n_wait;
            r_out_shift  <= n_out_shift;
            r_in_shift   <= n_in_shift;
            r_data_hold  <= n_data_hold;
            r_is_read    <= n_is_read;
            r_byte_stage <= n_byte_stage;
        end
    end

`ifndef SYNTHESIS
    a_idle_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_IDLE && !i_step) |=> (r_phase == PH_IDLE))
        else $error("sequencer left idle without a tick");
    a_drive_in_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result.data_drive |-> o_result.chip_enable)
        else $error("data driven outside an enabled frame");
    a_released_low: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_result.data_drive |-> !o_result.data_out)
        else $error("data_out high while released");
    a_done_from_stop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && o_result.done_res) |-> (r_phase == PH_STOP && !o_result.busy_res))
        else $error("done outside the stop phase");
`endif

endmodule

`default_nettype wire

// ===== hdl/three_wire_serial_register_master_top.sv =====
// Top level: three-wire serial register master with valid/ready channels.
// Depends on tws_pkg, tws_channels and tws_seq.
//
//   channel    dir  contents
//   i_in_ch    in   one tick: start_req, opcode, reg_address, write_data, data_in
//   o_out_ch   out  pin levels, busy_res, done_res, read_data after that tick
//   i_cfg_ch   in   half_period_ticks write (always ready)
//
// One item per cycle while the output register is empty or being taken; each accepted tick
// yields one result in the next cycle. Results sit in an output register; input stays ready while it is empty or
// being taken, so a pending result that is not taken holds the input in the same cycle.
// Synchronous active-low reset: idle, no result pending, half period 200 ticks.
`default_nettype none

module three_wire_serial_register_master_top
    import tws_pkg::*;
#(
    parameter int unsigned DELAY_WIDTH = 16
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    tws_in_if.sink     i_in_ch,
    tws_out_if.source  o_out_ch,
    tws_cfg_if.sink    i_cfg_ch
);

    logic [15:0] r_half_period;
    logic        r_out_valid;
    t_out_item   r_out_item;
    t_out_item   seq_result;
    logic        step;

    assign i_cfg_ch.ready = 1'b1;
    assign i_in_ch.ready  = !r_out_valid || o_out_ch.ready;
    assign step           = i_in_ch.valid && i_in_ch.ready;
    assign o_out_ch.valid = r_out_valid;
    assign o_out_ch.item  = r_out_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_half_period <= HALF_PERIOD_RESET;
        end else if (i_cfg_ch.valid) begin
            r_half_period <= i_cfg_ch.wdata;
        end
    end

    tws_seq #(
        .DELAY_WIDTH (DELAY_WIDTH)
    ) u_seq (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_step        (step),
        .i_item        (i_in_ch.item),
        .i_half_period (r_half_period),
        .o_result      (seq_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (step) begin
            r_out_valid <= 1'b1;
        end else if (o_out_ch.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_out_item <= seq_result;
        end
    end

`ifndef SYNTHESIS
    a_tick_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        step |=> r_out_valid)
        else $error("accepted tick produced no result");
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !o_out_ch.ready) |-> !step)
        else $error("tick accepted over a pending result");
    a_done_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (step && seq_result.done_res) |=> (r_out_item.done_res && !r_out_item.busy_res))
        else $error("done result lost or busy");
`endif

endmodule

`default_nettype wire

// ===== dv/tb_top.sv =====
// Self-checking testbench for three_wire_serial_register_master_top.
// Depends on tws_pkg, tws_channels and the top level; a pin-level predictor checks every tick result.

module tb_top;
    import tws_pkg::*;

    class pin_scoreboard;
        t_phase      cur_phase;
        logic [2:0]  bit_idx;
        int unsigned wait_cnt;
        logic [7:0]  tx_shift;
        logic [7:0]  rx_shift;
        logic [7:0]  wr_hold;
        bit          reading;
        bit          second_byte;
        logic [15:0] half_period;
        t_out_item   expected_pins[$];
        int unsigned mismatches;
        int unsigned checked;
        int unsigned accesses;
        int unsigned reads;

        function new();
            cur_phase   = PH_IDLE;
            bit_idx     = '0;
            wait_cnt    = 0;
            tx_shift    = '0;
            rx_shift    = '0;
            wr_hold     = '0;
            reading     = 1'b0;
            second_byte = 1'b0;
            half_period = HALF_PERIOD_RESET;
            mismatches  = 0;
            checked     = 0;
            accesses    = 0;
            reads       = 0;
        endfunction

        // Advance the pin sequencer by one accepted tick and queue the pins it shows.
        function void note_tick(t_in_item it);
            t_out_item   pins;
            int unsigned hold;
            bit          done;
            hold = (half_period == 16'd0) ? 1 : half_period;
            done = 1'b0;
            if (cur_phase == PH_IDLE) begin
                if (it.start_req) begin
                    reading     = (it.opcode == OP_READ);
                    tx_shift    = reading ? (it.reg_address | READ_CMD_MASK) : it.reg_address;
                    wr_hold     = it.write_data;
                    if (reading) begin
                        rx_shift = '0;
                        reads++;
                    end
                    second_byte = 1'b0;
                    bit_idx     = '0;
                    wait_cnt    = 0;
                    cur_phase   = PH_CE_LOW;
                    accesses++;
                end
            end else if (wait_cnt + 1 < hold) begin
                wait_cnt++;
            end else begin
                wait_cnt = 0;
                case (cur_phase)
                    PH_CE_LOW:  cur_phase = PH_CLK_LOW;
                    PH_CLK_LOW: cur_phase = PH_CE_HIGH;
                    PH_CE_HIGH: begin
                        cur_phase   = PH_SET;
                        bit_idx     = '0;
                        second_byte = 1'b0;
                    end
                    PH_SET: begin
                        // sample the released data line just before the rising edge
                        if (second_byte && reading && it.data_in)
                            rx_shift[bit_idx] = 1'b1;
                        cur_phase = PH_RISE;
                    end
                    PH_RISE:    cur_phase = PH_FALL;
                    PH_FALL: begin
                        if (bit_idx == 3'(BITS_PER_BYTE - 1)) begin
                            if (!second_byte) begin
                                second_byte = 1'b1;
                                bit_idx     = '0;
                                tx_shift    = reading ? 8'h00 : wr_hold;
                                cur_phase   = PH_SET;
                            end else begin
                                cur_phase = PH_STOP;
                            end
                        end else begin
                            bit_idx   = bit_idx + 3'd1;
                            cur_phase = PH_SET;
                        end
                    end
                    PH_STOP: begin
                        cur_phase = PH_IDLE;
                        done      = 1'b1;
                    end
                    default:    cur_phase = PH_IDLE;
                endcase
            end
            pins.chip_enable  = (cur_phase >= PH_CE_HIGH) && (cur_phase <= PH_FALL);
            pins.serial_clock = (cur_phase == PH_RISE);
            pins.data_drive   = (cur_phase >= PH_SET) && (cur_phase <= PH_FALL)
                                && !(second_byte && reading);
            pins.data_out     = pins.data_drive && tx_shift[bit_idx];
            pins.busy_res     = (cur_phase != PH_IDLE);
            pins.done_res     = done;
            pins.read_data    = rx_shift;
            expected_pins.push_back(pins);
        endfunction

        function void cmp_field(string name, logic [7:0] want, logic [7:0] got);
            if (got !== want) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("result %0d: %s expected %0h got %0h", checked, name, want, got);
            end
        endfunction

        function void check_pins(t_out_item got);
            t_out_item want;
            if (expected_pins.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("result with no tick outstanding: %0h", got);
                return;
            end
            want = expected_pins.pop_front();
            checked++;
            cmp_field("chip_enable", 8'(want.chip_enable), 8'(got.chip_enable));
            cmp_field("serial_clock", 8'(want.serial_clock), 8'(got.serial_clock));
            cmp_field("data_out", 8'(want.data_out), 8'(got.data_out));
            cmp_field("data_drive", 8'(want.data_drive), 8'(got.data_drive));
            cmp_field("busy_res", 8'(want.busy_res), 8'(got.busy_res));
            cmp_field("done_res", 8'(want.done_res), 8'(got.done_res));
            cmp_field("read_data", want.read_data, got.read_data);
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;

    tws_in_if  in_ch();
    tws_out_if out_ch();
    tws_cfg_if cfg_ch();

    pin_scoreboard sb;
    bit            in_steady;
    bit            out_steady;
    int unsigned   ticks_sent;
    int unsigned   settings_used;

    logic [15:0] random_periods[8] = '{16'd1, 16'd3, 16'd1, 16'd2, 16'd0, 16'd1, 16'd4, 16'd1};

    three_wire_serial_register_master_top #(
        .DELAY_WIDTH(16)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in_ch (in_ch),
        .o_out_ch(out_ch),
        .i_cfg_ch(cfg_ch)
    );

    always begin
        i_clk = 1'b0;
        #10;
        i_clk = 1'b1;
        #10;
    end

    function automatic int draw_gap(bit steady);
        return steady ? 0 : $urandom_range(0, 14);
    endfunction

    function automatic t_in_item rand_tick(bit start);
        t_in_item it;
        it.start_req   = start;
        it.opcode      = 1'($urandom);
        it.reg_address = 8'($urandom);
        it.write_data  = 8'($urandom);
        it.data_in     = 1'($urandom);
        return it;
    endfunction

    task automatic send_tick(t_in_item it);
        int gap;
        gap = draw_gap(in_steady);
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.item  <= it;
        do @(posedge i_clk); while (!(in_ch.valid && in_ch.ready));
        sb.note_tick(it);
        ticks_sent++;
    endtask

    // Launch one access and keep ticking until the predictor is idle again.
    // With noisy set, ticks during the access carry stray starts and random data_in.
    task automatic run_access(logic op, logic [7:0] addr, logic [7:0] wdata,
                              logic [7:0] rx_pattern, bit noisy);
        t_in_item it;
        it             = rand_tick(1'b1);
        it.opcode      = op;
        it.reg_address = addr;
        it.write_data  = wdata;
        send_tick(it);
        while (sb.cur_phase != PH_IDLE) begin
            it = rand_tick(noisy ? 1'($urandom) : 1'b0);
            if (!noisy)
                it.data_in = rx_pattern[sb.bit_idx];
            send_tick(it);
        end
    endtask

    task automatic drain();
        in_ch.valid <= 1'b0;
        do @(posedge i_clk); while (sb.expected_pins.size() != 0);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_half_period(logic [15:0] ticks);
        cfg_ch.valid <= 1'b1;
        cfg_ch.wdata <= ticks;
        do @(posedge i_clk); while (!(cfg_ch.valid && cfg_ch.ready));
        cfg_ch.valid   <= 1'b0;
        sb.half_period  = ticks;
        settings_used++;
        @(posedge i_clk);
    endtask

    // result side: random stalls per item
    initial begin
        int stall;
        out_ch.ready = 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            stall = draw_gap(out_steady);
            if (stall > 0) begin
                out_ch.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            out_ch.ready <= 1'b1;
            do @(posedge i_clk); while (!(out_ch.valid && out_ch.ready));
        end
    end

    always @(posedge i_clk) begin
        if (out_ch.valid === 1'b1 && out_ch.ready === 1'b1)
            sb.check_pins(out_ch.item);
    end

    initial begin
        int unsigned budget_end;
        t_in_item    first_tick;
        i_rst_n       = 1'b0;
        in_ch.valid   = 1'b0;
        in_ch.item    = '0;
        cfg_ch.valid  = 1'b0;
        cfg_ch.wdata  = '0;
        in_steady     = 1'b1;
        out_steady    = 1'b1;
        ticks_sent    = 0;
        settings_used = 0;
        sb            = new();
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // start a write at the reset half period and hold through the first
        // phase change, then finish the access at a short period
        first_tick             = rand_tick(1'b1);
        first_tick.opcode      = OP_WRITE;
        first_tick.reg_address = 8'hA5;
        first_tick.write_data  = 8'h3C;
        send_tick(first_tick);
        repeat (210) send_tick(rand_tick(1'b0));
        drain();

        in_steady  = 1'b0;
        out_steady = 1'b0;
        write_half_period(16'd1);
        while (sb.cur_phase != PH_IDLE)
            send_tick(rand_tick(1'b0));
        run_access(OP_READ, 8'h00, 8'hFF, 8'hFF, 1'b0);   // command bit 0 forced high
        run_access(OP_READ, 8'hFE, 8'h00, 8'h00, 1'b0);   // read clears the old byte
        run_access(OP_WRITE, 8'hFF, 8'h00, 8'hFF, 1'b0);  // read_data must hold
        run_access(OP_WRITE, 8'h00, 8'hFF, 8'h00, 1'b1);  // stray starts while busy
        run_access(OP_READ, 8'h81, 8'h5A, 8'hA5, 1'b1);
        repeat (3) send_tick(rand_tick(1'b0));
        drain();
        write_half_period(16'd0);                         // zero acts as one tick
        run_access(OP_READ, 8'h55, 8'h00, 8'h3C, 1'b0);
        drain();
        write_half_period(16'd2);
        run_access(OP_WRITE, 8'hAA, 8'h55, 8'h00, 1'b1);
        drain();
        // widest period: the predictor must hold the idle pins steady
        write_half_period(16'hFFFF);
        repeat (20) send_tick(rand_tick(1'b0));
        drain();

        foreach (random_periods[p]) begin
            write_half_period(random_periods[p]);
            budget_end = ticks_sent + 50;
            while (ticks_sent < budget_end) begin
                in_steady  = ($urandom_range(0, 5) == 0);
                out_steady = ($urandom_range(0, 5) == 0);
                if ($urandom_range(0, 9) < 8)
                    run_access(1'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                               1'($urandom));
                else
                    send_tick(rand_tick(1'b0));
            end
            drain();
        end

        drain();
        repeat (8) @(posedge i_clk);
        $display("Ran %0d accesses (%0d reads) over %0d ticks and %0d period settings,",
                 sb.accesses, sb.reads, ticks_sent, settings_used);
        $display("checked %0d results, %0d mismatching fields, %0d results outstanding",
                 sb.checked, sb.mismatches, sb.expected_pins.size());
        if (sb.mismatches == 0 && sb.expected_pins.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    initial begin
        #40_000_000;
        $display("Timeout: run did not complete");
        $display("Simulation FAILED");
        $finish;
    end

endmodule

// ===== filelist.f =====
hdl/tws_pkg.sv
hdl/tws_channels.sv
hdl/tws_seq.sv
hdl/three_wire_serial_register_master_top.sv
dv/tb_top.sv
